### rtl/core/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

	localparam int MAX_HEAP_BYTES_DEF = 4096;
	localparam int HDR_W              = 12;
	localparam int OFF_W              = 13;
	localparam int SIZE_W             = 12;
	localparam int REQ_TYPE_W         = 2;
	localparam int STATUS_W           = 2;
	localparam int FMT_LEN_MAX        = 4096;

	localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 12'd4084;

	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC    = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_FREE     = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_COALESCE = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE     = 2'd1;
	localparam logic [STATUS_W-1:0] STS_ALREADY_FREE = 2'd2;

	typedef enum logic [3:0] {
		ST_FMT_CLR,
		ST_FMT_HDR,
		ST_FMT_SEN,
		ST_IDLE,
		ST_A_EV,
		ST_A_WR2,
		ST_F_EV,
		ST_C_EV0,
		ST_C_EV,
		ST_OUT
	} state_t;

endpackage

### rtl/core/ffha_if.sv
// Channel interfaces of the first-fit heap allocator: request, result, configuration.
interface ffha_req_if;
	logic                             valid;
	logic                             ready;
	logic [ffha_pkg::REQ_TYPE_W-1:0]  req_type;
	logic [ffha_pkg::SIZE_W-1:0]      request_bytes;
	logic [ffha_pkg::SIZE_W-1:0]      free_address;

	modport source(output valid, output req_type, output request_bytes,
		output free_address, input ready);
	modport sink(input valid, input req_type, input request_bytes,
		input free_address, output ready);
endinterface

interface ffha_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ffha_pkg::STATUS_W-1:0]  status;
	logic [ffha_pkg::SIZE_W-1:0]    block_address;

	modport source(output valid, output status, output block_address, input ready);
	modport sink(input valid, input status, input block_address, output ready);
endinterface

interface ffha_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ffha_pkg::SIZE_W-1:0]  heap_size;

	modport source(output valid, output heap_size, input ready);
	modport sink(input valid, input heap_size, output ready);
endinterface

### rtl/core/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
module ffha_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over an implicit block list: top level.
//
// One request is taken at a time; the result sits in an output register until
// transferred, and the next request is taken the cycle after. The header store
// is one RAM with a registered read, and a single 13-bit adder and comparator
// walks it one header per cycle. Free reads the block header and then gives
// the result. Allocate walks the headers until one fits or the list ends, with
// one more write when the block is split. Coalesce reads the first header and
// then walks the rest. Request type 3 and a malformed free address go straight
// to the result. After reset and after every heap_size transfer the store is
// cleared and formatted, with no request taken; the configuration channel is
// always ready.
module first_fit_heap_allocator_unit #(
	parameter int MAX_HEAP_BYTES = ffha_pkg::MAX_HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp,
	ffha_cfg_if.sink    cfg
);

	import ffha_pkg::*;

	localparam int DEPTH    = MAX_HEAP_BYTES / 8;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int HEAP_CAP = (MAX_HEAP_BYTES / 8) * 8;
	localparam int CLR_N    = (DEPTH < FMT_LEN_MAX / 8) ? DEPTH : FMT_LEN_MAX / 8;

	localparam logic [OFF_W-1:0] CAP_OFF  =
		OFF_W'((HEAP_CAP > FMT_LEN_MAX) ? FMT_LEN_MAX : HEAP_CAP);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(CLR_N - 1);
	localparam logic [OFF_W-1:0] OFF_FIRST = 13'd4;

	function automatic logic [IDX_W-1:0] slot(input logic [OFF_W-1:0] o);
		logic [OFF_W+IDX_W-1:0] w;
		w = (OFF_W+IDX_W)'(o >> 3);
		return w[IDX_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [IDX_W-1:0]    clr_q, clr_d;
	logic [SIZE_W-1:0]   heap_size_q;
	logic [OFF_W-1:0]    sent_q, sent_d;
	logic [OFF_W-1:0]    off_q, off_d;
	logic [OFF_W-1:0]    nxt_q, nxt_d;
	logic [OFF_W-1:0]    need_q, need_d;
	logic [HDR_W-1:0]    cur_raw_q, cur_raw_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [SIZE_W-1:0]   res_addr_q, res_addr_d;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [HDR_W-1:0] wdata, rdata;

	logic             req_xfer, rsp_xfer, cfg_xfer;
	logic [OFF_W-1:0] fmt_round, fmt_len;
	logic [OFF_W-1:0] free_hdr;
	logic             free_bad;
	logic [OFF_W-1:0] rd_len, cur_len, merge_sum, merge_len;
	logic             merge;
	logic [OFF_W-1:0] step_base, step_len, step_nxt;
	logic             step_end;
	logic             fit, split;
	logic [OFF_W-1:0] rem;

	ffha_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req_xfer = req.valid && req.ready;
	assign rsp_xfer = rsp.valid && rsp.ready;
	assign cfg_xfer = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	assign fmt_round = (OFF_W'(heap_size_q) + 13'd19) & ~13'd7;
	assign fmt_len   = (fmt_round > CAP_OFF) ? CAP_OFF : fmt_round;

	assign free_hdr = OFF_W'(req.free_address) - 13'd4;
	assign free_bad = (req.free_address[2:0] != 3'd0) || (req.free_address == '0);

	// shared walk adder
	assign rd_len    = {1'b0, rdata[HDR_W-1:3], 3'b000};
	assign cur_len   = {1'b0, cur_raw_q[HDR_W-1:3], 3'b000};
	assign merge_sum = cur_len + rd_len;
	assign merge_len = {1'b0, merge_sum[HDR_W-1:3], 3'b000};
	assign merge     = !cur_raw_q[0] && !rdata[0];
	assign step_base = (state_q == ST_C_EV && !merge) ? nxt_q : off_q;
	assign step_len  = (state_q == ST_C_EV && merge) ? merge_len : rd_len;
	assign step_nxt  = step_base + step_len;
	assign step_end  = step_nxt >= sent_q;

	assign fit   = !rdata[0] && (rd_len >= need_q);
	assign rem   = rd_len - need_q;
	assign split = rem >= 13'd8;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FMT_CLR: if (clr_q == CLR_LAST) state_d = ST_FMT_HDR;
			ST_FMT_HDR: state_d = ST_FMT_SEN;
			ST_FMT_SEN: state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_xfer) begin
					case (req.req_type)
						REQ_ALLOC:    state_d = ST_A_EV;
						REQ_FREE:     state_d = (free_bad || free_hdr >= sent_q) ?
							ST_OUT : ST_F_EV;
						REQ_COALESCE: state_d = ST_C_EV0;
						default:      state_d = ST_OUT;
					endcase
				end
			end
			ST_A_EV: begin
				if (rd_len == '0) begin
					state_d = ST_OUT;
				end else if (fit) begin
					state_d = split ? ST_A_WR2 : ST_OUT;
				end else if (step_end) begin
					state_d = ST_OUT;
				end
			end
			ST_A_WR2: state_d = ST_OUT;
			ST_F_EV:  state_d = ST_OUT;
			ST_C_EV0: if (rd_len == '0 || step_end) state_d = ST_OUT; else state_d = ST_C_EV;
			ST_C_EV:  if (rd_len == '0 || step_end) state_d = ST_OUT;
			ST_OUT:   if (rsp_xfer) state_d = ST_IDLE;
			default:  state_d = ST_FMT_CLR;
		endcase
		if (cfg_xfer) begin
			state_d = ST_FMT_CLR;
		end
	end

	always_comb begin
		we           = 1'b0;
		waddr        = slot(off_q);
		wdata        = '0;
		raddr        = slot(step_nxt);
		clr_d        = clr_q;
		sent_d       = sent_q;
		off_d        = off_q;
		nxt_d        = nxt_q;
		need_d       = need_q;
		cur_raw_d    = cur_raw_q;
		res_status_d = res_status_q;
		res_addr_d   = res_addr_q;
		req.ready    = 1'b0;
		rsp.valid    = 1'b0;
		unique case (state_q)
			ST_FMT_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + 1'b1;
			end
			ST_FMT_HDR: begin
				we     = 1'b1;
				waddr  = slot(OFF_FIRST);
				wdata  = HDR_W'(fmt_len - 13'd8);
				sent_d = fmt_len - 13'd4;
			end
			ST_FMT_SEN: begin
				we    = 1'b1;
				waddr = slot(sent_q);
				wdata = HDR_W'(1);
			end
			ST_IDLE: begin
				req.ready    = 1'b1;
				raddr        = (req.req_type == REQ_FREE) ? slot(free_hdr) : slot(OFF_FIRST);
				off_d        = (req.req_type == REQ_FREE) ? free_hdr : OFF_FIRST;
				need_d       = (OFF_W'(req.request_bytes) + 13'd11) & ~13'd7;
				res_status_d = (req.req_type == REQ_FREE) ? STS_ALREADY_FREE : STS_OK;
				res_addr_d   = '0;
			end
			ST_A_EV: begin
				off_d = step_nxt;
				if (rd_len == '0) begin
					res_status_d = STS_NO_SPACE;
				end else if (fit) begin
					off_d      = off_q;
					we         = 1'b1;
					res_addr_d = SIZE_W'(off_q + 13'd4);
					if (split) begin
						wdata     = HDR_W'(need_q) | HDR_W'(1);
						cur_raw_d = HDR_W'(rem);
					end else begin
						wdata = rdata | HDR_W'(1);
					end
				end else if (step_end) begin
					res_status_d = STS_NO_SPACE;
				end
			end
			ST_A_WR2: begin
				we    = 1'b1;
				waddr = slot(off_q + need_q);
				wdata = cur_raw_q;
			end
			ST_F_EV: begin
				if (rdata[0]) begin
					we           = 1'b1;
					wdata        = rdata & ~HDR_W'(1);
					res_status_d = STS_OK;
				end
			end
			ST_C_EV0: begin
				cur_raw_d = rdata;
				nxt_d     = step_nxt;
			end
			ST_C_EV: begin
				nxt_d = step_nxt;
				if (rd_len != '0) begin
					if (merge) begin
						we        = 1'b1;
						wdata     = merge_len[HDR_W-1:0];
						cur_raw_d = merge_len[HDR_W-1:0];
					end else begin
						off_d     = nxt_q;
						cur_raw_d = rdata;
					end
				end
			end
			ST_OUT: begin
				rsp.valid = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		if (cfg_xfer) begin
			clr_d = '0;
		end
	end

	assign rsp.status        = res_status_q;
	assign rsp.block_address = res_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FMT_CLR;
			clr_q       <= '0;
			heap_size_q <= HEAP_SIZE_RST;
			sent_q      <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			sent_q  <= sent_d;
			if (cfg_xfer) begin
				heap_size_q <= cfg.heap_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		off_q        <= off_d;
		nxt_q        <= nxt_d;
		need_q       <= need_d;
		cur_raw_q    <= cur_raw_d;
		res_status_q <= res_status_d;
		res_addr_q   <= res_addr_d;
	end

endmodule
